/* hw/rtl/bounded_lifo_stack_unit_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the bounded LIFO stack unit
// Shared concurrent-assertion wrappers, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_LIFO_STACK_UNIT_DEFINES_SVH
`define BOUNDED_LIFO_STACK_UNIT_DEFINES_SVH

// Same-cycle implication.
`define BLS_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BLS_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/bls_pkg.sv */
// ----------------------------------------------------------------------------
// bls_pkg
// Types and constants shared by the stack cells, the top level and the checker.
// ----------------------------------------------------------------------------
package bls_pkg;

  localparam int WordWidth  = 32;
  localparam int CountWidth = 5;

  typedef enum logic [2:0] {
    OP_PUSH = 3'd0,
    OP_POP  = 3'd1,
    OP_PEEK = 3'd2,
    OP_FIND = 3'd3,
    OP_REV  = 3'd4
  } opcode_t;

  // What every cell does on the next edge.
  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_PUSH = 2'd1,
    CELL_POP  = 2'd2,
    CELL_ROT  = 2'd3
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t cmd;
    logic      in_seg;   // cell lies before the tail of the rotated segment
    logic      is_tail;  // cell is the tail of the rotated segment
  } cell_ctrl_t;

  typedef struct packed {
    logic [2:0]           opcode;
    logic [WordWidth-1:0] data_in;
  } cmd_t;

  typedef struct packed {
    logic [WordWidth-1:0]  data_out;
    logic                  data_valid;
    logic                  found;
    logic [CountWidth-1:0] entry_count;
    logic                  is_empty;
    logic                  overflow;
  } rsp_t;

endpackage

/* hw/rtl/bounded_lifo_stack_unit.sv */
// ----------------------------------------------------------------------------
// bounded_lifo_stack_unit
// Fixed-depth LIFO stack built as a shifting chain of word cells.
// ----------------------------------------------------------------------------
// The stack lives in a row of DEPTH cells with the top of stack always in
// cell 0. Push, pop, peek and unused opcodes are answered straight from idle;
// a push with room or a pop with entries shifts the chain by one position.
// Contains and reverse run in states of their own over the n entries held;
// an empty contains or a reverse of under two entries is answered from idle.
// Both walk the stack by rotating a prefix of the chain left by one cell per
// cycle; contains compares the head cell against the key on each step with a
// single comparator and ends with the stack back in its original order.
// The last step of a walk waits while an older result is still stalled.
// The result register frees the output side, so a new command is taken
// whenever the unit is between commands and the result slot is empty or is
// being drained in the same cycle. Stored words need no reset.
module bounded_lifo_stack_unit #(
  parameter int DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  bls_pkg::cmd_t cmd,
  output logic          result_valid,
  input  logic          result_ready,
  output bls_pkg::rsp_t result
);

  localparam int W  = bls_pkg::WordWidth;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);
  localparam logic [CW-1:0] ONE  = CW'(1);
  localparam logic [CW-1:0] TWO  = CW'(2);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_REV  = 3'b010,
    S_SRCH = 3'b100
  } state_t;

  state_t        state, state_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] steps, steps_next;
  logic          hit, hit_next;
  logic [W-1:0]  key;

  logic                accept;
  logic                post_ok;
  logic                post;
  bls_pkg::rsp_t       post_rsp;
  bls_pkg::cell_cmd_t  cell_cmd;
  logic [CW-1:0]       rot_len;
  logic [CW-1:0]       rot_last;
  logic                hit_now;
  logic [CW+4:0]       count_ext;

  logic [W-1:0]        cell_word [DEPTH];
  bls_pkg::cell_ctrl_t cell_ctrl [DEPTH];

  // The result slot is free this cycle if empty or being taken.
  assign post_ok   = !result_valid || result_ready;
  assign cmd_ready = (state == S_IDLE) && post_ok;
  assign accept    = cmd_valid && cmd_ready;
  assign rot_last  = rot_len - ONE;
  assign hit_now   = hit || (cell_word[0] == key);

  // Sequencer: decode the command, drive the chain, build the result.
  always_comb begin
    state_next = state;
    count_next = count;
    steps_next = steps;
    hit_next   = hit;
    cell_cmd   = bls_pkg::CELL_HOLD;
    rot_len    = count;
    post       = 1'b0;
    post_rsp   = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (cmd.opcode)
            bls_pkg::OP_PUSH: begin
              post = 1'b1;
              if (count < FULL) begin
                cell_cmd   = bls_pkg::CELL_PUSH;
                count_next = count + ONE;
              end else begin
                // drop the word and flag it
                post_rsp.overflow = 1'b1;
              end
            end
            bls_pkg::OP_POP: begin
              post = 1'b1;
              if (count != '0) begin
                post_rsp.data_out   = cell_word[0];
                post_rsp.data_valid = 1'b1;
                cell_cmd            = bls_pkg::CELL_POP;
                count_next          = count - ONE;
              end
            end
            bls_pkg::OP_PEEK: begin
              post = 1'b1;
              if (count != '0) begin
                post_rsp.data_out   = cell_word[0];
                post_rsp.data_valid = 1'b1;
              end
            end
            bls_pkg::OP_FIND: begin
              if (count == '0) begin
                post = 1'b1;
              end else begin
                steps_next = count;
                hit_next   = 1'b0;
                state_next = S_SRCH;
              end
            end
            bls_pkg::OP_REV: begin
              if (count < TWO) begin
                post = 1'b1;
              end else begin
                steps_next = count;
                state_next = S_REV;
              end
            end
            default: post = 1'b1;
          endcase
        end
      end
      S_REV: begin
        // rotate prefixes of length n, n-1, ..., 2
        rot_len = steps;
        if (steps > TWO) begin
          cell_cmd   = bls_pkg::CELL_ROT;
          steps_next = steps - ONE;
        end else if (post_ok) begin
          cell_cmd   = bls_pkg::CELL_ROT;
          post       = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_SRCH: begin
        // n full rotations bring the order back; compare the head each step
        rot_len = count;
        if (steps > ONE) begin
          cell_cmd   = bls_pkg::CELL_ROT;
          hit_next   = hit_now;
          steps_next = steps - ONE;
        end else if (post_ok) begin
          cell_cmd       = bls_pkg::CELL_ROT;
          post           = 1'b1;
          post_rsp.found = hit_now;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    count_ext            = {5'b0, count_next};
    post_rsp.entry_count = count_ext[4:0];
    post_rsp.is_empty    = (count_next == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      steps        <= '0;
      hit          <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      steps <= steps_next;
      hit   <= hit_next;
      if (post) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Hold the search key and the pending result; no reset needed.
  always_ff @(posedge clk) begin
    if (accept) begin
      key <= cmd.data_in;
    end
    if (post) begin
      result <= post_rsp;
    end
  end

  // Cell chain: cell 0 is the top of stack.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [CW-1:0] IDX = CW'(i);
    logic [W-1:0] prev_w;
    logic [W-1:0] next_w;

    if (i == 0) begin : g_first
      assign prev_w = cmd.data_in;
    end else begin : g_mid
      assign prev_w = cell_word[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign next_w = cell_word[i];
    end else begin : g_inner
      assign next_w = cell_word[i+1];
    end

    assign cell_ctrl[i].cmd     = cell_cmd;
    assign cell_ctrl[i].in_seg  = (IDX < rot_last);
    assign cell_ctrl[i].is_tail = (IDX == rot_last);

    bls_cell u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl[i]),
      .prev_word (prev_w),
      .next_word (next_w),
      .head_word (cell_word[0]),
      .word      (cell_word[i])
    );
  end

endmodule

/* hw/rtl/bls_cell.sv */
// ----------------------------------------------------------------------------
// bls_cell
// One stack slot: holds a word, shifts toward either neighbor or takes the head.
// ----------------------------------------------------------------------------
module bls_cell (
  input  logic                           clk,
  input  bls_pkg::cell_ctrl_t            ctrl,
  input  logic [bls_pkg::WordWidth-1:0]  prev_word,
  input  logic [bls_pkg::WordWidth-1:0]  next_word,
  input  logic [bls_pkg::WordWidth-1:0]  head_word,
  output logic [bls_pkg::WordWidth-1:0]  word
);

  always_ff @(posedge clk) begin
    unique case (ctrl.cmd)
      bls_pkg::CELL_HOLD: word <= word;
      bls_pkg::CELL_PUSH: word <= prev_word;
      bls_pkg::CELL_POP:  word <= next_word;
      bls_pkg::CELL_ROT: begin
        // rotate the segment left: head wraps to the tail
        if (ctrl.is_tail) begin
          word <= head_word;
        end else if (ctrl.in_seg) begin
          word <= next_word;
        end
      end
      default: word <= word;
    endcase
  end

endmodule

/* hw/rtl/bls_checker.sv */
// ----------------------------------------------------------------------------
// bls_checker
// Port-level assertions for the stack unit, attached by bind.
// ----------------------------------------------------------------------------
`include "bounded_lifo_stack_unit_defines.svh"

module bls_checker (
  input logic          clk,
  input logic          rst,
  input logic          cmd_valid,
  input logic          cmd_ready,
  input bls_pkg::cmd_t cmd,
  input logic          result_valid,
  input logic          result_ready,
  input bls_pkg::rsp_t result
);

  logic cmd_xfer;
  logic quick_op;
  logic rsp_stall;
  logic slot_free;

  assign cmd_xfer  = cmd_valid && cmd_ready;
  assign quick_op  = (cmd.opcode == bls_pkg::OP_PUSH) || (cmd.opcode == bls_pkg::OP_POP) ||
                     (cmd.opcode == bls_pkg::OP_PEEK);
  assign rsp_stall = result_valid && !result_ready;
  assign slot_free = !result_valid || result_ready;

  // A stalled result must hold.
  `BLS_ASSERT_NXT(a_rsp_hold, rsp_stall, result_valid && $stable(result), "stalled result changed")

  // Never take a command while a result would be overwritten.
  `BLS_ASSERT_IMP(a_no_overrun, cmd_xfer, slot_free, "command taken with result slot busy")

  // Push, pop and peek answer on the next cycle.
  `BLS_ASSERT_NXT(a_quick_rsp, cmd_xfer && quick_op, result_valid, "single-cycle op gave no result")

endmodule

bind bounded_lifo_stack_unit bls_checker u_bls_checker (
  .clk          (clk),
  .rst          (rst),
  .cmd_valid    (cmd_valid),
  .cmd_ready    (cmd_ready),
  .cmd          (cmd),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

/* verif/bounded_lifo_stack_unit_tb.sv */
// ----------------------------------------------------------------------------
// bounded_lifo_stack_unit_tb
// Self-checking bench for the bounded LIFO stack unit. A shadow stack in the
// bench predicts every response; a monitor compares each response transfer
// field by field against the oldest prediction. Directed cases cover the
// empty and full stack, then random episodes grow, shrink, fill and reverse
// the stack under random gaps on the command side and stalls on the result side.
// ----------------------------------------------------------------------------
module bounded_lifo_stack_unit_tb;

  localparam int WordWidth   = bls_pkg::WordWidth;
  localparam int CountWidth  = bls_pkg::CountWidth;
  localparam int StackDepth  = 16;
  localparam int IdxBits     = $clog2(StackDepth);
  localparam int HalfPeriod  = 6;
  localparam int ResetCycles = 9;
  localparam int RandomItems = 1350;
  // The longest walk is contains on a full stack; give it plenty of margin
  // before the final verdict.
  localparam int SettleCycles = 4 * StackDepth;
  // Slowest run is about 1500 items, each with the longest gap, walk and stall.
  localparam int CycleLimit = 500000;
  // Opcodes outside the defined set; the unit must treat them as no-ops.
  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  logic           clk;
  logic           rst;
  logic           cmd_valid;
  logic           cmd_ready;
  bls_pkg::cmd_t  cmd;
  logic           result_valid;
  logic           result_ready;
  bls_pkg::rsp_t  result;

  // Shadow copy of the stack; slot 0 is the bottom.
  logic [WordWidth-1:0] shadow_words [StackDepth];
  int                   shadow_count;

  bls_pkg::rsp_t expected_rsps [$];
  int   fail_count;
  int   items_sent;
  int   cycle_count;
  int   ready_hold;
  bit   gaps_on;
  bit   stalls_on;

  bounded_lifo_stack_unit #(
    .DEPTH(StackDepth)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd_ready    (cmd_ready),
    .cmd          (cmd),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #HalfPeriod clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Shadow stack: apply one command and return the response it must produce.
  // --------------------------------------------------------------------------
  function automatic bls_pkg::rsp_t apply_to_stack(bls_pkg::cmd_t c);
    bls_pkg::rsp_t        r;
    logic [WordWidth-1:0] tmp;
    int                   lo;
    int                   hi;
    r = '0;
    case (c.opcode)
      bls_pkg::OP_PUSH: begin
        if (shadow_count < StackDepth) begin
          shadow_words[IdxBits'(shadow_count)] = c.data_in;
          shadow_count++;
        end else begin
          // Full: drop the word and flag it.
          r.overflow = 1'b1;
        end
      end
      bls_pkg::OP_POP: begin
        if (shadow_count > 0) begin
          shadow_count--;
          r.data_out   = shadow_words[IdxBits'(shadow_count)];
          r.data_valid = 1'b1;
        end
      end
      bls_pkg::OP_PEEK: begin
        if (shadow_count > 0) begin
          r.data_out   = shadow_words[IdxBits'(shadow_count - 1)];
          r.data_valid = 1'b1;
        end
      end
      bls_pkg::OP_FIND: begin
        for (int i = 0; i < shadow_count; i++) begin
          if (shadow_words[IdxBits'(i)] == c.data_in) r.found = 1'b1;
        end
      end
      bls_pkg::OP_REV: begin
        lo = 0;
        hi = shadow_count - 1;
        while (lo < hi) begin
          tmp                          = shadow_words[IdxBits'(lo)];
          shadow_words[IdxBits'(lo)]   = shadow_words[IdxBits'(hi)];
          shadow_words[IdxBits'(hi)]   = tmp;
          lo++;
          hi--;
        end
      end
      default: begin
        // Spare opcodes: report count and empty flag only.
      end
    endcase
    r.entry_count = CountWidth'(shadow_count);
    r.is_empty    = (shadow_count == 0);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Data helpers
  // --------------------------------------------------------------------------
  // Mix full-range words with a small pool and corner values so that
  // contains hits and duplicates are common.
  function automatic logic [WordWidth-1:0] rand_word();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 7);
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'h0000_0000;
          1: return 32'hFFFF_FFFF;
          2: return 32'h8000_0000;
          default: return 32'h0000_0001;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // Search key: half the time a word that is stored right now.
  function automatic logic [WordWidth-1:0] search_key();
    if (shadow_count > 0 && $urandom_range(0, 1) == 1)
      return shadow_words[IdxBits'($urandom_range(0, shadow_count - 1))];
    return rand_word();
  endfunction

  // --------------------------------------------------------------------------
  // Command side
  // --------------------------------------------------------------------------
  // Send one command: idle for a random gap, raise valid, hold until the
  // transfer, then record the prediction. Valid is left high; the next call
  // either replaces the payload or drops valid at the following falling edge.
  task automatic send_cmd(logic [2:0] op, logic [WordWidth-1:0] data);
    int gap;
    gap = gaps_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      @(negedge clk);
      cmd_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    cmd_valid      <= 1'b1;
    cmd.opcode     <= op;
    cmd.data_in    <= data;
    forever begin
      @(posedge clk);
      if (cmd_ready) break;
    end
    expected_rsps.push_back(apply_to_stack(cmd));
    if (op <= bls_pkg::OP_REV) items_sent++;
  endtask

  // Drop valid and hold off until every predicted response has arrived.
  task automatic hold_until_drained();
    @(negedge clk);
    cmd_valid <= 1'b0;
    while (expected_rsps.size() != 0) @(posedge clk);
  endtask

  // One random command; push_pct sets the share of pushes, half the rest are pops.
  task automatic send_random_op(int push_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < push_pct)
      send_cmd(bls_pkg::OP_PUSH, rand_word());
    else if (r < push_pct + (100 - push_pct) / 2)
      send_cmd(bls_pkg::OP_POP, rand_word());
    else begin
      case ($urandom_range(0, 2))
        0: send_cmd(bls_pkg::OP_PEEK, rand_word());
        1: send_cmd(bls_pkg::OP_FIND, search_key());
        default: send_cmd(bls_pkg::OP_REV, rand_word());
      endcase
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stall after each transfer, then accept.
  // --------------------------------------------------------------------------
  initial begin
    result_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (ready_hold > 0) begin
        result_ready <= 1'b0;
        ready_hold--;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  task automatic check_field(string name, logic [WordWidth-1:0] want,
                             logic [WordWidth-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  // Compare every response transfer against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (expected_rsps.size() == 0) begin
        $error("response transfer with no prediction pending");
        fail_count++;
      end else begin
        check_field("data_out", expected_rsps[0].data_out, result.data_out);
        check_field("data_valid", WordWidth'(expected_rsps[0].data_valid),
                    WordWidth'(result.data_valid));
        check_field("found", WordWidth'(expected_rsps[0].found),
                    WordWidth'(result.found));
        check_field("entry_count", WordWidth'(expected_rsps[0].entry_count),
                    WordWidth'(result.entry_count));
        check_field("is_empty", WordWidth'(expected_rsps[0].is_empty),
                    WordWidth'(result.is_empty));
        check_field("overflow", WordWidth'(expected_rsps[0].overflow),
                    WordWidth'(result.overflow));
        void'(expected_rsps.pop_front());
      end
      ready_hold = stalls_on ? $urandom_range(0, 7) : 0;
    end
  end

  // Watchdog: end the run if it hangs.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CycleLimit) break;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Every opcode but push on an empty stack, spare opcodes included.
  task automatic test_empty_stack();
    send_cmd(bls_pkg::OP_POP,  32'hFFFF_FFFF);
    send_cmd(bls_pkg::OP_PEEK, 32'h0000_0000);
    send_cmd(bls_pkg::OP_FIND, 32'h0000_0000);
    send_cmd(bls_pkg::OP_REV,  32'hFFFF_FFFF);
    for (logic [3:0] op = {1'b0, OP_SPARE_LO}; op <= {1'b0, OP_SPARE_HI}; op++)
      send_cmd(op[2:0], $urandom);
    hold_until_drained();
  endtask

  // Reverse of a single entry, fill to the top, push into a full stack,
  // search the bottom, reverse a full stack and read the new top.
  task automatic test_full_stack();
    logic [WordWidth-1:0] bottom;
    bottom = 32'hFFFF_FFFF;
    send_cmd(bls_pkg::OP_PUSH, bottom);
    send_cmd(bls_pkg::OP_REV,  $urandom);
    while (shadow_count < StackDepth - 1) send_cmd(bls_pkg::OP_PUSH, $urandom);
    send_cmd(bls_pkg::OP_PUSH, 32'h0000_0000);
    send_cmd(bls_pkg::OP_PUSH, $urandom);
    send_cmd(bls_pkg::OP_FIND, bottom);
    send_cmd(bls_pkg::OP_REV,  $urandom);
    send_cmd(bls_pkg::OP_PEEK, $urandom);
    send_cmd(bls_pkg::OP_POP,  $urandom);
    hold_until_drained();
  endtask

  // Random episodes until enough real commands have been sent.
  task automatic test_random_traffic();
    int start_count;
    int len;
    start_count = items_sent;
    while (items_sent - start_count < RandomItems) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          // Grow-biased mix.
          len = $urandom_range(8, 24);
          repeat (len) send_random_op(55);
        end
        3, 4: begin
          // Shrink-biased mix.
          len = $urandom_range(8, 24);
          repeat (len) send_random_op(20);
        end
        5, 6: begin
          // Fill to the top, overflow, search, reverse and search again, then pop a random number of entries.
          while (shadow_count < StackDepth) send_cmd(bls_pkg::OP_PUSH, rand_word());
          repeat ($urandom_range(1, 3)) send_cmd(bls_pkg::OP_PUSH, rand_word());
          send_cmd(bls_pkg::OP_FIND, search_key());
          send_cmd(bls_pkg::OP_REV, rand_word());
          send_cmd(bls_pkg::OP_FIND, search_key());
          repeat ($urandom_range(0, StackDepth + 1)) send_cmd(bls_pkg::OP_POP, rand_word());
        end
        7: begin
          // Switch idling modes so long stretches without gaps occur too.
          gaps_on   = ($urandom_range(0, 2) != 0);
          stalls_on = ($urandom_range(0, 2) != 0);
        end
        8: begin
          // Noise: a few spare opcodes, then one real command.
          repeat ($urandom_range(1, 3))
            send_cmd(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)), $urandom);
          send_random_op(40);
        end
        default: begin
          // Back off until the unit has delivered everything, then burst.
          hold_until_drained();
          repeat ($urandom_range(4, 12)) send_random_op(45);
        end
      endcase
    end
    hold_until_drained();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst          = 1'b1;
    cmd_valid    = 1'b0;
    cmd          = '0;
    shadow_count = 0;
    fail_count   = 0;
    items_sent   = 0;
    ready_hold   = 0;
    gaps_on      = 1'b1;
    stalls_on    = 1'b1;
    repeat (ResetCycles) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_stack();
    test_full_stack();
    test_random_traffic();

    // Let any late or stray response show up before the verdict.
    repeat (SettleCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* bounded_lifo_stack_unit.f */
+incdir+hw/rtl
hw/rtl/bls_pkg.sv
hw/rtl/bls_cell.sv
hw/rtl/bounded_lifo_stack_unit.sv
hw/rtl/bls_checker.sv
verif/bounded_lifo_stack_unit_tb.sv
